>>> hw/rtl/one_bit_drum_voice_synth_unit_macros.svh
// assertion macros for the drum voice synth
`ifndef ONE_BIT_DRUM_VOICE_SYNTH_UNIT_MACROS_SVH
`define ONE_BIT_DRUM_VOICE_SYNTH_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define DV_ASSERT_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define DV_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define DV_ASSERT_IMPL(label, clk, rst_n, a, c)
`define DV_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

>>> hw/rtl/dvs_pkg.sv
// shared types and constants of the drum voice synth
`default_nettype none
package dvs_pkg;
    localparam int unsigned CNT_BITS = 16;
    localparam logic [15:0] SNARE_SEED = 16'h34A4;
    localparam logic [15:0] HAT_SEED = 16'h4A8A;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_CALC,
        ST_OUT
    } state_t;

    // request to the serial remainder unit
    typedef struct packed {
        logic        start;
        logic [15:0] dividend;
        logic [9:0]  divisor;
    } div_req_t;

    // reply of the serial remainder unit
    typedef struct packed {
        logic       done;
        logic       zero;
    } div_rsp_t;
endpackage
`default_nettype wire

>>> hw/rtl/dvs_stream_if.sv
// valid/ready channel carrying a payload
`default_nettype none
interface dvs_stream_if #(parameter int unsigned W = 1);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/dvs_rem_serial.sv
// bit-serial restoring remainder unit, one quotient bit per cycle
`default_nettype none
`include "one_bit_drum_voice_synth_unit_macros.svh"
module dvs_rem_serial (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire dvs_pkg::div_req_t req,
    output dvs_pkg::div_rsp_t     rsp
);
    logic [15:0] shift_reg, shift_next;
    logic [10:0] rem_reg, rem_next;
    logic [9:0]  dsr_reg, dsr_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [10:0] trial;

    // load the operands on start, else shift one dividend bit into the partial remainder
    always_comb
    begin
        shift_next = shift_reg;
        rem_next = rem_reg;
        dsr_next = dsr_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial = {rem_reg[9:0], shift_reg[15]};
        if (req.start)
        begin
            shift_next = req.dividend;
            rem_next = '0;
            dsr_next = req.divisor;
            cnt_next = 5'd16;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            shift_next = {shift_reg[14:0], 1'b0};
            rem_next = (trial >= {1'b0, dsr_reg}) ? trial - {1'b0, dsr_reg} : trial;
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done = done_reg;
    assign rsp.zero = (rem_reg == '0);

    `DV_ASSERT_IMPL(a_done_after_busy, clk, rst_n, done_reg, !busy_reg)
    `DV_ASSERT_IMPL(a_count_busy, clk, rst_n, busy_reg, cnt_reg != 5'd0)
    `DV_ASSERT_NEXT(a_start_busy, clk, rst_n, req.start, busy_reg)
endmodule
`default_nettype wire

>>> hw/rtl/one_bit_drum_voice_synth_unit.sv
// drum voice synth top: voice state, remainder sequencing and result register
// one tick runs three serial remainder passes in turn, then the voice update and the result register
// one tick at a time; output back-pressure and the shared bit-serial remainder unit set the rate
// asynchronous active-low reset returns all voice state to its initial values
// a waiting result is held until the output transfer
`default_nettype none
`include "one_bit_drum_voice_synth_unit_macros.svh"
module one_bit_drum_voice_synth_unit #(
    parameter int unsigned KNOB_BITS = 10
) (
    input wire logic clk,
    input wire logic rst_n,
    dvs_stream_if.sink   in_ch,
    dvs_stream_if.source out_ch
);
    localparam int unsigned KB = KNOB_BITS;

    dvs_pkg::state_t state_reg, state_next;
    logic [1:0] phase_reg, phase_next;
    logic [3:0] zero_reg, zero_next;
    logic [9:0] pk, ps, ph, pw;
    logic tk, ts, th, tw, rel, seq;
    logic [4*KB+5:0] hold_reg;

    logic [13:0] kc_reg; logic [15:0] ke_reg; logic kl_reg;
    logic [12:0] sc_reg; logic sl_reg; logic [15:0] sn_reg;
    logic [10:0] hc_reg; logic [15:0] hn_reg;
    logic [8:0] tc_reg, tp_reg; logic tl_reg;
    logic [13:0] kc0; logic [12:0] sc0; logic [10:0] hc0; logic [8:0] tc0;
    logic [13:0] kc1; logic [12:0] sc1; logic [10:0] hc1; logic [9:0] tc1;
    logic snare_early;
    logic [9:0] sdiv, hdiv;
    dvs_pkg::div_req_t req;
    dvs_pkg::div_rsp_t rsp;
    logic [6:0] res_reg;
    logic hl_v;
    logic hl_reg;

    // knob scaling to ten bits
    function automatic logic [9:0] knob10(input logic [KB-1:0] raw);
        logic [15:0] w;
        w = {{(16-KB){1'b0}}, raw};
        if (KB >= 10) w = w >> (KB - 10);
        else w = w << (10 - KB);
        return w[9:0];
    endfunction

    // input field unpack from held tick
    assign tk = hold_reg[4*KB+5];
    assign ts = hold_reg[4*KB+4];
    assign th = hold_reg[4*KB+3];
    assign tw = hold_reg[4*KB+2];
    assign pk = knob10(hold_reg[4*KB+1 -: KB]);
    assign ps = knob10(hold_reg[3*KB+1 -: KB]);
    assign ph = knob10(hold_reg[2*KB+1 -: KB]);
    assign pw = knob10(hold_reg[KB+1 -: KB]);
    assign rel = hold_reg[1];
    assign seq = hold_reg[0];

    // counters after trigger and increment
    assign kc0 = tk ? 14'd1 : kc_reg;
    assign sc0 = ts ? 13'd1 : sc_reg;
    assign hc0 = th ? 11'd1 : hc_reg;
    assign tc0 = (rel && !seq) ? 9'd0 : (tw ? 9'd1 : tc_reg);
    assign kc1 = kc0 + 14'd1;
    assign sc1 = sc0 + 13'd1;
    assign hc1 = hc0 + 11'd1;
    assign tc1 = {1'b0, tc0} + 10'd1;
    assign snare_early = ({2'b0, sc1} < {5'b0, ps} + 15'h90);
    assign sdiv = snare_early ? {5'b0, ps[9:5]} + 10'd3 : {4'b0, ps[9:4]} + 10'd5;
    assign hdiv = 10'((11'(ph) + 11'd190) >> 6);

    // remainder job per phase; phase 3 marks the cycle after an input transfer
    always_comb
    begin
        req.start = 1'b0;
        req.dividend = '0;
        req.divisor = 10'd1;
        unique case (phase_next)
            2'd0: begin req.dividend = {3'b0, sc1}; req.divisor = sdiv; end
            2'd1: begin req.dividend = {5'b0, hc1}; req.divisor = hdiv; end
            2'd2: begin req.dividend = {6'b0, tc1}; req.divisor = (tp_reg == 0) ? 10'd1 : {1'b0, tp_reg}; end
            default: begin req.dividend = '0; req.divisor = 10'd1; end
        endcase
        if (state_reg == dvs_pkg::ST_DIV
            && (phase_reg == 2'd3 || (rsp.done && phase_reg != 2'd2)))
            req.start = 1'b1;
    end

    dvs_rem_serial u_rem (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        zero_next = zero_reg;
        in_ch.ready = 1'b0;
        unique case (state_reg)
            dvs_pkg::ST_IDLE:
            begin
                in_ch.ready = 1'b1;
                if (in_ch.valid)
                begin
                    state_next = dvs_pkg::ST_DIV;
                    phase_next = 2'd3;
                end
            end
            dvs_pkg::ST_DIV:
            begin
                if (phase_reg == 2'd3) phase_next = 2'd0;
                else if (rsp.done)
                begin
                    zero_next[phase_reg] = rsp.zero;
                    if (phase_reg == 2'd2) state_next = dvs_pkg::ST_CALC;
                    else phase_next = phase_reg + 2'd1;
                end
            end
            dvs_pkg::ST_CALC: state_next = dvs_pkg::ST_OUT;
            dvs_pkg::ST_OUT:
            begin
                if (!out_ch.valid || out_ch.ready) state_next = dvs_pkg::ST_IDLE;
            end
            default: state_next = dvs_pkg::ST_IDLE;
        endcase
    end

    logic ovalid_reg;
    assign hl_v = zero_reg[1] && (hc1 <= 11'(12'(ph) + 12'(ph >> 2) + 12'h1FF))
                  && hc0 != 0 && (hn_reg[0] == hn_reg[1]);

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready) hold_reg <= in_ch.data;
    end

    // state registers and voice update at end of tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dvs_pkg::ST_IDLE; phase_reg <= '0; zero_reg <= '0;
            kc_reg <= '0; ke_reg <= 16'd2; kl_reg <= 1'b0;
            sc_reg <= '0; sl_reg <= 1'b0; sn_reg <= dvs_pkg::SNARE_SEED;
            hc_reg <= '0; hn_reg <= dvs_pkg::HAT_SEED;
            tc_reg <= '0; tp_reg <= 9'd1; tl_reg <= 1'b0;
            ovalid_reg <= 1'b0; res_reg <= '0; hl_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next; phase_reg <= phase_next; zero_reg <= zero_next;
            if (state_reg == dvs_pkg::ST_CALC)
            begin
                // kick
                if (kc0 != 0)
                begin
                    logic [15:0] e;
                    e = (kc0 == 14'd1) ? 16'd2 : ke_reg;
                    if ({2'b0, kc1} > {3'b0, pk, 3'b0} + 16'h1FF)
                    begin
                        kc_reg <= '0; kl_reg <= 1'b0; ke_reg <= e;
                    end
                    else if ({2'b0, kc1} == e)
                    begin
                        kc_reg <= kc1;
                        kl_reg <= ~kl_reg;
                        ke_reg <= e + (e >> 4) + (16'd64 - {10'b0, pk[9:4]});
                    end
                    else
                    begin
                        kc_reg <= kc1; ke_reg <= e;
                    end
                end
                else kc_reg <= kc0;
                // snare
                if (sc0 != 0)
                begin
                    if ({1'b0, sc1} > {2'b0, ps, 2'b0} + 14'h1FF)
                    begin
                        sc_reg <= '0; sl_reg <= 1'b0;
                    end
                    else
                    begin
                        sc_reg <= sc1;
                        if ((snare_early ? sc1[7] : sc1[5]) || zero_reg[0])
                        begin
                            sn_reg <= {sn_reg[0] == sn_reg[1], sn_reg[15:1]};
                            if (sn_reg[0] == sn_reg[1]) sl_reg <= ~sl_reg;
                        end
                    end
                end
                else sc_reg <= sc0;
                // hat
                if (hc0 != 0)
                begin
                    if ({1'b0, hc1} > 12'(ph) + 12'(ph >> 2) + 12'h1FF) hc_reg <= '0;
                    else
                    begin
                        hc_reg <= hc1;
                        if (zero_reg[1]) hn_reg <= {hn_reg[0] == hn_reg[1], hn_reg[15:1]};
                    end
                end
                else hc_reg <= hc0;
                hl_reg <= hl_v;
                // tone
                if (tc0 != 0)
                begin
                    if (zero_reg[2])
                    begin
                        tp_reg <= 9'(10'd50 + (10'd255 - {2'b0, pw[9:2]}));
                        tc_reg <= 9'd1;
                        tl_reg <= ~tl_reg;
                    end
                    else tc_reg <= tc1[8:0];
                end
                else
                begin
                    tc_reg <= tc0;
                    if (!seq) tl_reg <= 1'b0;
                end
            end
            // result register
            if (state_reg == dvs_pkg::ST_OUT && (!ovalid_reg || out_ch.ready))
            begin
                res_reg <= {3'(kl_reg) + 3'(sl_reg) + 3'(hl_reg) + 3'(tl_reg),
                            kl_reg, sl_reg, hl_reg, tl_reg};
                ovalid_reg <= 1'b1;
            end
            else if (out_ch.valid && out_ch.ready) ovalid_reg <= 1'b0;
        end
    end

    assign out_ch.valid = ovalid_reg;
    assign out_ch.data = res_reg;

    `DV_ASSERT_IMPL(a_ready_idle, clk, rst_n, in_ch.ready, state_reg == dvs_pkg::ST_IDLE)
    `DV_ASSERT_IMPL(a_mix_range, clk, rst_n, out_ch.valid, res_reg[6:4] <= 3'd4)
    `DV_ASSERT_NEXT(a_calc_out, clk, rst_n, state_reg == dvs_pkg::ST_CALC,
        state_reg == dvs_pkg::ST_OUT)
endmodule
`default_nettype wire
